@@ rtl/k_nearest_insertion_list_defines.svh @@
// assertion macros for the k nearest insertion list checker
// no dependencies
`ifndef K_NEAREST_INSERTION_LIST_DEFINES_SVH
`define K_NEAREST_INSERTION_LIST_DEFINES_SVH

// property checked only outside reset
`define KNIL_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define KNIL_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/knil_pkg.sv @@
// shared types and constants for the k nearest insertion list
// no dependencies
package knil_pkg;

    localparam int LIST_DEPTH_DEF     = 32;
    localparam int DIST_BITS_DEF      = 32;
    localparam int NUM_BOXES_DEF      = 16384;
    localparam int POINTS_PER_BOX_DEF = 65536;

    localparam int OP_W     = 2;
    localparam int DIST_W   = 32;
    localparam int BOX_W    = 14;
    localparam int POINT_W  = 16;
    localparam int RANK_W   = 5;
    localparam int KREG_W   = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [KREG_W-1:0] K_IN_USE_RESET = 6'd32;
    localparam logic              REG_K_IN_USE   = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_OFFER = 2'd1,
        OP_DRAIN = 2'd2
    } t_op;

    typedef struct packed {
        logic clear;
        logic insert;
        logic load;
    } t_dp_cmd;

endpackage

@@ rtl/knil_dp.sv @@
// slot list with parallel compare and shift insertion, and the output payload register
// depends on knil_pkg
module knil_dp #(
    parameter int LIST_DEPTH     = knil_pkg::LIST_DEPTH_DEF,
    parameter int DIST_BITS      = knil_pkg::DIST_BITS_DEF,
    parameter int NUM_BOXES      = knil_pkg::NUM_BOXES_DEF,
    parameter int POINTS_PER_BOX = knil_pkg::POINTS_PER_BOX_DEF,
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int K_W   = $clog2(LIST_DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  knil_pkg::t_dp_cmd            i_cmd,
    input  logic [IDX_W-1:0]             i_rd_idx,
    input  logic [K_W-1:0]               i_k_act,
    input  logic [knil_pkg::DIST_W-1:0]  i_distance,
    input  logic [knil_pkg::BOX_W-1:0]   i_box_index,
    input  logic [knil_pkg::POINT_W-1:0] i_point_number,
    output logic [knil_pkg::RANK_W-1:0]  o_rank,
    output logic                         o_entry_valid,
    output logic [knil_pkg::DIST_W-1:0]  o_entry_distance,
    output logic [knil_pkg::BOX_W-1:0]   o_entry_box,
    output logic [knil_pkg::POINT_W-1:0] o_entry_point
);

    logic [DIST_BITS-1:0]         r_dist  [LIST_DEPTH];
    logic [knil_pkg::BOX_W-1:0]   r_box   [LIST_DEPTH];
    logic [knil_pkg::POINT_W-1:0] r_point [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]        r_valid;
    logic [LIST_DEPTH-1:0]        le;
    logic [DIST_BITS-1:0]         cand_dist;
    logic                         cand_ok;
    logic                         do_insert;

    logic [knil_pkg::RANK_W-1:0]  r_o_rank;
    logic                         r_o_valid;
    logic [knil_pkg::DIST_W-1:0]  r_o_dist;
    logic [knil_pkg::BOX_W-1:0]   r_o_box;
    logic [knil_pkg::POINT_W-1:0] r_o_point;

    assign cand_dist = DIST_BITS'({{DIST_BITS{1'b0}}, i_distance});
    assign cand_ok   = (32'(i_box_index) < 32'(NUM_BOXES))
                     && (32'(i_point_number) < 32'(POINTS_PER_BOX));
    assign do_insert = i_cmd.insert && cand_ok;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_slot
        logic in_k;
        logic prev_le;

        assign le[i] = r_valid[i] && (r_dist[i] <= cand_dist);
        assign in_k  = K_W'(i) < i_k_act;
        if (i == 0) begin : g_head
            assign prev_le = 1'b1;
        end else begin : g_body
            assign prev_le = le[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else if (i_cmd.clear) begin
                r_valid[i] <= 1'b0;
            end else if (do_insert && in_k && !le[i]) begin
                if (prev_le) begin
                    r_valid[i] <= 1'b1;
                end else begin
                    r_valid[i] <= r_valid[(i > 0) ? i - 1 : 0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (do_insert && in_k && !le[i]) begin
                if (prev_le) begin
                    r_dist[i]  <= cand_dist;
                    r_box[i]   <= i_box_index;
                    r_point[i] <= i_point_number;
                end else begin
                    r_dist[i]  <= r_dist[(i > 0) ? i - 1 : 0];
                    r_box[i]   <= r_box[(i > 0) ? i - 1 : 0];
                    r_point[i] <= r_point[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // empty ranks read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_rank  <= knil_pkg::RANK_W'(i_rd_idx);
            r_o_valid <= r_valid[i_rd_idx];
            r_o_dist  <= r_valid[i_rd_idx]
                       ? knil_pkg::DIST_W'({{knil_pkg::DIST_W{1'b0}}, r_dist[i_rd_idx]})
                       : '0;
            r_o_box   <= r_valid[i_rd_idx] ? r_box[i_rd_idx] : '0;
            r_o_point <= r_valid[i_rd_idx] ? r_point[i_rd_idx] : '0;
        end
    end

    assign o_rank           = r_o_rank;
    assign o_entry_valid    = r_o_valid;
    assign o_entry_distance = r_o_dist;
    assign o_entry_box      = r_o_box;
    assign o_entry_point    = r_o_point;

endmodule

@@ rtl/knil_ctrl.sv @@
// controller: input handshake, drain sequencing and output valid
// depends on knil_pkg
module knil_ctrl #(
    parameter int LIST_DEPTH = knil_pkg::LIST_DEPTH_DEF,
    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int K_W   = $clog2(LIST_DEPTH + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [knil_pkg::OP_W-1:0] i_op,
    input  logic                      i_out_ready,
    input  logic                      i_cfg_clear,
    input  logic [K_W-1:0]            i_k_act,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    output logic                      o_last,
    output knil_pkg::t_dp_cmd         o_cmd,
    output logic [IDX_W-1:0]          o_rd_idx
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             r_last;
    logic             n_last;
    logic             accept;
    logic             out_free;
    logic             idx_last;
    logic             is_clear;
    logic             is_offer;
    logic             is_drain;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign idx_last = (K_W'(r_idx) + K_W'(1)) == i_k_act;

    always_comb begin
        is_clear = 1'b0;
        is_offer = 1'b0;
        is_drain = 1'b0;
        unique case (knil_pkg::t_op'(i_op))
            knil_pkg::OP_CLEAR: is_clear = 1'b1;
            knil_pkg::OP_OFFER: is_offer = 1'b1;
            knil_pkg::OP_DRAIN: is_drain = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_last      = r_last;
        o_cmd       = '0;
        o_cmd.clear  = i_cfg_clear || (accept && is_clear);
        o_cmd.insert = accept && is_offer;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_drain) begin
                    n_state = S_DRAIN;
                    n_idx   = '0;
                end
            end
            S_DRAIN: begin
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_last      = idx_last;
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_last      = r_last;
    assign o_rd_idx    = r_idx;

endmodule

@@ rtl/k_nearest_insertion_list.sv @@
// top level of the k nearest insertion list: register port, controller and slot datapath
// depends on knil_pkg, knil_ctrl, knil_dp
//
//   channel   handshake                  payload
//   in        i_in_valid / o_in_ready    i_op, i_distance, i_box_index, i_point_number
//   out       o_out_valid / i_out_ready  o_rank, o_entry_valid, o_entry_distance,
//                                        o_entry_box, o_entry_point, o_last
//   config    psel / penable / pready    paddr, pwrite, pwdata, prdata
//
// clear and offer act on the list when they are accepted, an offer compares against all slots at once
// drain sends k slots through the single output register, one slot a cycle unless the output stalls
// output stalls hold the drain, offers wait until the drain is done
// synchronous reset empties the list and sets k_in_use to 32, no clearing pass
module k_nearest_insertion_list #(
    parameter int LIST_DEPTH     = knil_pkg::LIST_DEPTH_DEF,
    parameter int DIST_BITS      = knil_pkg::DIST_BITS_DEF,
    parameter int NUM_BOXES      = knil_pkg::NUM_BOXES_DEF,
    parameter int POINTS_PER_BOX = knil_pkg::POINTS_PER_BOX_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [knil_pkg::OP_W-1:0]     i_op,
    input  logic [knil_pkg::DIST_W-1:0]   i_distance,
    input  logic [knil_pkg::BOX_W-1:0]    i_box_index,
    input  logic [knil_pkg::POINT_W-1:0]  i_point_number,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [knil_pkg::RANK_W-1:0]   o_rank,
    output logic                          o_entry_valid,
    output logic [knil_pkg::DIST_W-1:0]   o_entry_distance,
    output logic [knil_pkg::BOX_W-1:0]    o_entry_box,
    output logic [knil_pkg::POINT_W-1:0]  o_entry_point,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [knil_pkg::PADDR_W-1:0]  paddr,
    input  logic [knil_pkg::PDATA_W-1:0]  pwdata,
    output logic [knil_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int K_W   = $clog2(LIST_DEPTH + 1);

    logic [knil_pkg::KREG_W-1:0] r_k_in_use;
    logic [K_W-1:0]              k_act;
    logic                        cfg_wr;
    knil_pkg::t_dp_cmd           cmd;
    logic [IDX_W-1:0]            rd_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == knil_pkg::REG_K_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_in_use <= knil_pkg::K_IN_USE_RESET;
        end else if (cfg_wr) begin
            r_k_in_use <= pwdata[knil_pkg::KREG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == knil_pkg::REG_K_IN_USE)
                  ? knil_pkg::PDATA_W'(r_k_in_use) : '0;

    // zero means one, above the depth saturates
    always_comb begin
        priority if (r_k_in_use == '0) begin
            k_act = K_W'(1);
        end else if (32'(r_k_in_use) > 32'(LIST_DEPTH)) begin
            k_act = K_W'(LIST_DEPTH);
        end else begin
            k_act = K_W'(r_k_in_use);
        end
    end

    knil_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_ready (i_out_ready),
        .i_cfg_clear (cfg_wr),
        .i_k_act     (k_act),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_last      (o_last),
        .o_cmd       (cmd),
        .o_rd_idx    (rd_idx)
    );

    knil_dp #(
        .LIST_DEPTH     (LIST_DEPTH),
        .DIST_BITS      (DIST_BITS),
        .NUM_BOXES      (NUM_BOXES),
        .POINTS_PER_BOX (POINTS_PER_BOX)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_idx         (rd_idx),
        .i_k_act          (k_act),
        .i_distance       (i_distance),
        .i_box_index      (i_box_index),
        .i_point_number   (i_point_number),
        .o_rank           (o_rank),
        .o_entry_valid    (o_entry_valid),
        .o_entry_distance (o_entry_distance),
        .o_entry_box      (o_entry_box),
        .o_entry_point    (o_entry_point)
    );

endmodule

@@ rtl/knil_checker.sv @@
// port level checks for the k nearest insertion list, bound to the top level
// depends on knil_pkg and k_nearest_insertion_list_defines.svh
`include "k_nearest_insertion_list_defines.svh"

module knil_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic [knil_pkg::OP_W-1:0]     i_op,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [knil_pkg::RANK_W-1:0]   o_rank,
    input logic                          o_entry_valid,
    input logic [knil_pkg::DIST_W-1:0]   o_entry_distance,
    input logic [knil_pkg::BOX_W-1:0]    o_entry_box,
    input logic [knil_pkg::POINT_W-1:0]  o_entry_point,
    input logic                          o_last
);

    logic drain_acc;
    logic out_acc;

    assign drain_acc = i_in_valid && o_in_ready && (i_op == knil_pkg::OP_DRAIN);
    assign out_acc   = o_out_valid && i_out_ready;

    `KNIL_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_rank) && $stable(o_last)), "stalled transaction changed")
    `KNIL_ASSERT(a_drain_blocks, i_clk, i_rst_n, drain_acc |=> !o_in_ready, "input taken right after a drain started")
    `KNIL_ASSERT(a_rank_step, i_clk, i_rst_n, (out_acc && !o_last) |=> (o_out_valid && (o_rank == $past(o_rank) + 5'd1)), "drain ranks not consecutive")
    `KNIL_ASSERT(a_empty_zero, i_clk, i_rst_n, (o_out_valid && !o_entry_valid) |-> ((o_entry_distance == '0) && (o_entry_box == '0) && (o_entry_point == '0)), "empty rank carries data")
    `KNIL_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind k_nearest_insertion_list knil_checker u_knil_checker (.*);
